// ----- src/fqr_pkg.sv -----
// Shared types, sizes and helpers for the FIFO queue with read-out.
// Used by fqr_front, fqr_cmdq, fqr_back and the top level; depends on nothing.
package fqr_pkg;

  localparam int DEPTH      = 64;
  localparam int DATA_W     = 32;
  localparam int ADDR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int CMDQ_DEPTH = 4;
  localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);
  localparam int RDO_W      = $clog2(CMDQ_DEPTH + 2);

  typedef enum logic [2:0] {
    FUNC_ENQ   = 3'd0,
    FUNC_DEQ   = 3'd1,
    FUNC_DISP  = 3'd2,
    FUNC_EMPTY = 3'd3,
    FUNC_SIZE  = 3'd4
  } func_t;

  typedef enum logic [2:0] {
    KIND_INSERTED  = 3'd0,
    KIND_REMOVED   = 3'd1,
    KIND_UNDERFLOW = 3'd2,
    KIND_EMPTY     = 3'd3,
    KIND_ELEMENT   = 3'd4,
    KIND_NOT_EMPTY = 3'd5,
    KIND_SIZE      = 3'd6,
    KIND_OVERFLOW  = 3'd7
  } kind_t;

  typedef enum logic {
    BK_IDLE = 1'b0,
    BK_WALK = 1'b1
  } back_state_t;

  typedef struct packed {
    logic [2:0]               func;
    logic signed [DATA_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    kind_t                    kind;
    logic signed [DATA_W-1:0] data;
    logic                     last;
  } out_item_t;

  // One decoded request handed from front to back
  typedef struct packed {
    kind_t                    kind;
    logic                     rd;
    logic [ADDR_W-1:0]        addr;
    logic [CNT_W-1:0]         len;
    logic signed [DATA_W-1:0] data;
  } cmd_t;

  function automatic logic [ADDR_W-1:0] ptr_next(input logic [ADDR_W-1:0] p);
    logic [ADDR_W-1:0] n;
    if (p == ADDR_W'(DEPTH - 1)) begin
      n = '0;
    end else begin
      n = p + ADDR_W'(1);
    end
    return n;
  endfunction

endpackage

// ----- src/fqr_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; no package dependency.
module fqr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- src/fqr_cmdq.sv -----
// Short command queue between the front and back halves.
// Depends on fqr_pkg for cmd_t and the queue depth.
module fqr_cmdq (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  fqr_pkg::cmd_t     push_cmd,
  input  logic              pop,
  output fqr_pkg::cmd_t     head_cmd,
  output logic              full,
  output logic              empty
);

  fqr_pkg::cmd_t                  slot_r [fqr_pkg::CMDQ_DEPTH];
  logic [fqr_pkg::CMDQ_AW-1:0]    wp_r, wp_nxt;
  logic [fqr_pkg::CMDQ_AW-1:0]    rp_r, rp_nxt;
  logic [fqr_pkg::CMDQ_AW:0]      cnt_r, cnt_nxt;
  logic                           do_push, do_pop;

  assign full     = (cnt_r == (fqr_pkg::CMDQ_AW + 1)'(fqr_pkg::CMDQ_DEPTH));
  assign empty    = (cnt_r == '0);
  assign head_cmd = slot_r[rp_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;

  always_comb begin
    wp_nxt  = do_push ? wp_r + fqr_pkg::CMDQ_AW'(1) : wp_r;
    rp_nxt  = do_pop  ? rp_r + fqr_pkg::CMDQ_AW'(1) : rp_r;
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + (fqr_pkg::CMDQ_AW + 1)'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - (fqr_pkg::CMDQ_AW + 1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wp_r] <= push_cmd;
    end
  end

endmodule

// ----- src/fqr_front.sv -----
// Front half: takes requests, keeps head, tail and fill count, writes the
// store on enqueue and pushes one decoded command per answered request.
// Depends on fqr_pkg.
module fqr_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  fqr_pkg::in_item_t             in_item,
  input  logic                          q_full,
  output logic                          q_push,
  output fqr_pkg::cmd_t                 q_cmd,
  input  logic                          rd_done,
  output logic                          ram_we,
  output logic [fqr_pkg::ADDR_W-1:0]    ram_waddr,
  output logic [fqr_pkg::DATA_W-1:0]    ram_wdata
);

  logic [fqr_pkg::ADDR_W-1:0] head_r, head_nxt;
  logic [fqr_pkg::ADDR_W-1:0] tail_r, tail_nxt;
  logic [fqr_pkg::CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [fqr_pkg::RDO_W-1:0]  rd_out_r, rd_out_nxt;
  logic                       room;
  logic                       hold;
  logic                       acc;
  logic                       rd_inc;

  assign room      = (cnt_r < fqr_pkg::CNT_W'(fqr_pkg::DEPTH));
  // hold a writing enqueue until every queued store read has been taken
  assign hold      = (in_item.func == fqr_pkg::FUNC_ENQ) && room && (rd_out_r != '0);
  assign in_ready  = !q_full && !hold;
  assign acc       = in_valid && in_ready;
  assign ram_waddr = tail_r;
  assign ram_wdata = in_item.value;

  always_comb begin
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    cnt_nxt    = cnt_r;
    q_push     = 1'b0;
    ram_we     = 1'b0;
    rd_inc     = 1'b0;
    q_cmd.kind = fqr_pkg::KIND_INSERTED;
    q_cmd.rd   = 1'b0;
    q_cmd.addr = head_r;
    q_cmd.len  = fqr_pkg::CNT_W'(1);
    q_cmd.data = '0;
    case (in_item.func)
      fqr_pkg::FUNC_ENQ: begin
        q_push = acc;
        if (room) begin
          ram_we   = acc;
          if (acc) begin
            tail_nxt = fqr_pkg::ptr_next(tail_r);
            cnt_nxt  = cnt_r + fqr_pkg::CNT_W'(1);
          end
        end else begin
          q_cmd.kind = fqr_pkg::KIND_OVERFLOW;
        end
      end
      fqr_pkg::FUNC_DEQ: begin
        q_push = acc;
        if (cnt_r == '0) begin
          q_cmd.kind = fqr_pkg::KIND_UNDERFLOW;
        end else begin
          q_cmd.kind = fqr_pkg::KIND_REMOVED;
          q_cmd.rd   = 1'b1;
          rd_inc     = acc;
          if (acc) begin
            head_nxt = fqr_pkg::ptr_next(head_r);
            cnt_nxt  = cnt_r - fqr_pkg::CNT_W'(1);
          end
        end
      end
      fqr_pkg::FUNC_DISP: begin
        q_push = acc;
        if (cnt_r == '0) begin
          q_cmd.kind = fqr_pkg::KIND_EMPTY;
        end else begin
          q_cmd.kind = fqr_pkg::KIND_ELEMENT;
          q_cmd.rd   = 1'b1;
          q_cmd.len  = cnt_r;
          rd_inc     = acc;
        end
      end
      fqr_pkg::FUNC_EMPTY: begin
        q_push     = acc;
        q_cmd.kind = (cnt_r == '0) ? fqr_pkg::KIND_EMPTY : fqr_pkg::KIND_NOT_EMPTY;
      end
      fqr_pkg::FUNC_SIZE: begin
        q_push     = acc;
        q_cmd.kind = fqr_pkg::KIND_SIZE;
        q_cmd.data = fqr_pkg::DATA_W'(cnt_r);
      end
      default: begin
        // undefined operation: drop silently
        q_push = 1'b0;
      end
    endcase
  end

  always_comb begin
    rd_out_nxt = rd_out_r;
    if (rd_inc && !rd_done) begin
      rd_out_nxt = rd_out_r + fqr_pkg::RDO_W'(1);
    end else if (rd_done && !rd_inc) begin
      rd_out_nxt = rd_out_r - fqr_pkg::RDO_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r   <= '0;
      tail_r   <= '0;
      cnt_r    <= '0;
      rd_out_r <= '0;
    end else begin
      head_r   <= head_nxt;
      tail_r   <= tail_nxt;
      cnt_r    <= cnt_nxt;
      rd_out_r <= rd_out_nxt;
    end
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= fqr_pkg::CNT_W'(fqr_pkg::DEPTH))
    else $error("fill count beyond depth");

  a_no_write_under_read: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> rd_out_r == '0)
    else $error("store written while a read is outstanding");

  a_rd_out_balance: assert property (@(posedge clk) disable iff (!rst_n)
    rd_done |-> (rd_out_r != '0))
    else $error("read completion without an outstanding read");

endmodule

// ----- src/fqr_back.sv -----
// Back half: pops commands, reads the store for dequeue and display, and
// drives the result beat through a single output register.
// Depends on fqr_pkg.
module fqr_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_empty,
  input  fqr_pkg::cmd_t                 q_cmd,
  output logic                          q_pop,
  output logic                          ram_re,
  output logic [fqr_pkg::ADDR_W-1:0]    ram_raddr,
  input  logic [fqr_pkg::DATA_W-1:0]    ram_rdata,
  output logic                          rd_done,
  output logic                          out_valid,
  input  logic                          out_ready,
  output fqr_pkg::out_item_t            out_item
);

  fqr_pkg::back_state_t        state_r, state_nxt;
  logic [fqr_pkg::ADDR_W-1:0]  addr_r, addr_nxt;
  logic [fqr_pkg::CNT_W-1:0]   left_r, left_nxt;
  fqr_pkg::kind_t              kind_r, kind_nxt;
  logic                        rd_pend_r, rd_pend_nxt;
  logic                        last_pend_r, last_pend_nxt;
  logic                        out_valid_r, out_valid_nxt;
  fqr_pkg::out_item_t          out_item_r, out_item_nxt;
  logic                        out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;
  assign ram_raddr = addr_r;

  always_comb begin
    state_nxt     = state_r;
    addr_nxt      = addr_r;
    left_nxt      = left_r;
    kind_nxt      = kind_r;
    rd_pend_nxt   = 1'b0;
    last_pend_nxt = last_pend_r;
    out_valid_nxt = out_valid_r;
    out_item_nxt  = out_item_r;
    q_pop         = 1'b0;
    ram_re        = 1'b0;
    rd_done       = 1'b0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    // store data lands in the (empty) output register
    if (rd_pend_r) begin
      out_valid_nxt      = 1'b1;
      out_item_nxt.kind  = kind_r;
      out_item_nxt.data  = $signed(ram_rdata);
      out_item_nxt.last  = last_pend_r;
      rd_done            = last_pend_r;
    end

    case (state_r)
      fqr_pkg::BK_IDLE: begin
        if (!rd_pend_r && !q_empty && out_free) begin
          q_pop = 1'b1;
          if (q_cmd.rd) begin
            state_nxt = fqr_pkg::BK_WALK;
            addr_nxt  = q_cmd.addr;
            left_nxt  = q_cmd.len;
            kind_nxt  = q_cmd.kind;
          end else begin
            out_valid_nxt     = 1'b1;
            out_item_nxt.kind = q_cmd.kind;
            out_item_nxt.data = q_cmd.data;
            out_item_nxt.last = 1'b1;
          end
        end
      end
      fqr_pkg::BK_WALK: begin
        if (!rd_pend_r && out_free) begin
          ram_re        = 1'b1;
          rd_pend_nxt   = 1'b1;
          last_pend_nxt = (left_r == fqr_pkg::CNT_W'(1));
          left_nxt      = left_r - fqr_pkg::CNT_W'(1);
          addr_nxt      = fqr_pkg::ptr_next(addr_r);
          if (left_r == fqr_pkg::CNT_W'(1)) begin
            state_nxt = fqr_pkg::BK_IDLE;
          end
        end
      end
      default: begin
        state_nxt = fqr_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fqr_pkg::BK_IDLE;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rd_pend_r   <= rd_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    addr_r      <= addr_nxt;
    left_r      <= left_nxt;
    kind_r      <= kind_nxt;
    last_pend_r <= last_pend_nxt;
    out_item_r  <= out_item_nxt;
  end

  a_land_in_empty_reg: assert property (@(posedge clk) disable iff (!rst_n)
    rd_pend_r |-> !out_valid_r)
    else $error("store data arrived while the output register was occupied");

  a_read_from_walk: assert property (@(posedge clk) disable iff (!rst_n)
    ram_re |-> (state_r == fqr_pkg::BK_WALK) && !q_pop)
    else $error("store read issued outside a walk");

endmodule

// ----- src/fifo_queue_with_readout_core.sv -----
// FIFO queue of signed 32-bit words with enqueue, dequeue, display and queries.
// Top level; depends on fqr_pkg, fqr_front, fqr_cmdq, fqr_back and fqr_ram.
//
// Every request is taken while the four-entry command queue has room and it
// is not held (see below); enqueue and the two queries each give one result
// beat, and such beats can leave one per cycle while out_ready stays high. A
// dequeue or display reads the store through the registered read port straight
// into the single output register: the back half takes the command, then for
// each stored word issues one read and lets it land in the output register
// before it issues the next. An enqueue that would write the store is held
// at the input until every queued dequeue or display has finished its reads.
// The store needs no clearing after reset: only occupied slots are read.
module fifo_queue_with_readout_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  fqr_pkg::in_item_t   in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output fqr_pkg::out_item_t  out_item
);

  fqr_pkg::cmd_t                push_cmd;
  fqr_pkg::cmd_t                head_cmd;
  logic                         q_push;
  logic                         q_pop;
  logic                         q_full;
  logic                         q_empty;
  logic                         rd_done;
  logic                         ram_we;
  logic [fqr_pkg::ADDR_W-1:0]   ram_waddr;
  logic [fqr_pkg::DATA_W-1:0]   ram_wdata;
  logic                         ram_re;
  logic [fqr_pkg::ADDR_W-1:0]   ram_raddr;
  logic [fqr_pkg::DATA_W-1:0]   ram_rdata;

  fqr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (push_cmd),
    .rd_done   (rd_done),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata)
  );

  fqr_cmdq u_cmdq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .pop      (q_pop),
    .head_cmd (head_cmd),
    .full     (q_full),
    .empty    (q_empty)
  );

  fqr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_cmd     (head_cmd),
    .q_pop     (q_pop),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .rd_done   (rd_done),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  fqr_ram #(
    .WIDTH (fqr_pkg::DATA_W),
    .DEPTH (fqr_pkg::DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule
